/* src/c1d_pkg.sv */
// ----------------------------------------------------------------------------
// c1d_pkg
// Shared types and constants of the four-channel 1-D convolution filter bank.
// ----------------------------------------------------------------------------
package c1d_pkg;

  localparam int CHANNELS    = 4;
  localparam int WEIGHT_BITS = 16;
  localparam int BIAS_BITS   = 32;
  localparam int RES_BITS    = 32;
  localparam int POS_BITS    = 16;
  localparam int FIDX_BITS   = 4;
  localparam int CFG_BITS    = 5;
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TAPS    = 2'd0,
    CFG_FILTERS = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  fsel;
    logic [1:0]  csel;
    logic [3:0]  tsel;
    logic        seq_start;
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

endpackage

/* src/c1d_front.sv */
// ----------------------------------------------------------------------------
// c1d_front
// Accepts input transactions, drops ignored kinds and out-of-range loads,
// and packs the rest for the queue.
// ----------------------------------------------------------------------------
module c1d_front import c1d_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 16,
  parameter int MAX_FILTERS = 16,
  parameter int DATA_W      = 64
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [3:0]                    filter_sel_i,
  input  logic [1:0]                    channel_sel_i,
  input  logic [3:0]                    tap_sel_i,
  input  logic signed [WEIGHT_BITS-1:0] weight_value_i,
  input  logic signed [BIAS_BITS-1:0]   bias_value_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_a_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_c_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_g_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_t_i,
  input  logic                          seq_start_i,
  input  logic                          full_i,
  output logic                          push_o,
  output item_ctl_t                     ctl_o,
  output logic [DATA_W-1:0]             data_o
);

  logic  keep;
  kind_e kind;

  assign kind       = kind_e'(kind_i);
  assign in_ready_o = !full_i;

  always_comb begin
    keep   = 1'b0;
    data_o = '0;
    case (kind)
      KIND_WEIGHT: begin
        keep   = (int'(filter_sel_i) < MAX_FILTERS) && (int'(tap_sel_i) < MAX_TAPS);
        data_o = DATA_W'($unsigned(weight_value_i));
      end
      KIND_BIAS: begin
        keep   = int'(filter_sel_i) < MAX_FILTERS;
        data_o = DATA_W'($unsigned(bias_value_i));
      end
      KIND_SAMPLE: begin
        keep   = 1'b1;
        data_o = DATA_W'({sample_a_i, sample_c_i, sample_g_i, sample_t_i});
      end
      default: begin
        keep   = 1'b0;
        data_o = '0;
      end
    endcase
  end

  assign ctl_o.kind      = kind;
  assign ctl_o.fsel      = filter_sel_i;
  assign ctl_o.csel      = channel_sel_i;
  assign ctl_o.tsel      = tap_sel_i;
  assign ctl_o.seq_start = seq_start_i;

  assign push_o = in_valid_i && !full_i && keep;

endmodule

/* src/c1d_fifo.sv */
// ----------------------------------------------------------------------------
// c1d_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module c1d_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* src/c1d_back.sv */
// ----------------------------------------------------------------------------
// c1d_back
// Executes queued transactions: weight and bias loads, window writes, and a
// multiply-accumulate pass per filter over all channels and taps.
// ----------------------------------------------------------------------------
module c1d_back import c1d_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 16,
  parameter int MAX_FILTERS = 16,
  parameter int DATA_W      = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [CFG_BITS-1:0]         taps_i,
  input  logic [CFG_BITS-1:0]         filters_i,
  input  logic                        item_valid_i,
  input  item_ctl_t                   item_ctl_i,
  input  logic [DATA_W-1:0]           item_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [FIDX_BITS-1:0]        filter_index_o,
  output logic [POS_BITS-1:0]         out_position_o,
  output logic signed [RES_BITS-1:0]  conv_value_o,
  output logic                        saturated_o,
  output logic                        last_of_run_o
);

  localparam int WDEPTH  = MAX_FILTERS * CHANNELS * MAX_TAPS;
  localparam int ADDR_W  = $clog2(WDEPTH);
  localparam int AW2     = ADDR_W + 8;
  localparam int BF_W    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int WIN_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TW      = $clog2(MAX_TAPS + 1);
  localparam int FW      = $clog2(MAX_FILTERS + 1);
  localparam int PW      = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACC_RAW = PW + $clog2(CHANNELS * MAX_TAPS) + 2;
  localparam int ACC_W   = (ACC_RAW > 34) ? ACC_RAW : 34;
  localparam logic [1:0] CH_LAST = 2'(CHANNELS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-32){1'b1}}, 32'h80000000};

  logic signed [WEIGHT_BITS-1:0] wmem [WDEPTH];
  logic signed [BIAS_BITS-1:0]   bmem [MAX_FILTERS];
  logic [CHANNELS*SAMPLE_BITS-1:0] win_mem [MAX_TAPS];

  back_state_e state_q, state_d;
  logic [TW-1:0]       fill_q, fill_base, fill_new, k_cfg, k_q;
  logic [FW-1:0]       nf_cfg, nf_q, f_q, f_d;
  logic [1:0]          c_q, c_d;
  logic [TW-1:0]       j_q, j_d;
  logic [POS_BITS-1:0] pos_q, pos_base, curpos_q;
  logic                start_run, issue, adv;
  logic                last_j, last_c, last_f;
  logic [TW-1:0]       win_idx, win_dist;
  logic [WIN_W-1:0]    np_q, np_d;
  logic [AW2-1:0]      rd_addr, ld_addr;

  logic                          v1_q, first1_q, last1_q;
  logic [FW-1:0]                 f1_q;
  logic signed [WEIGHT_BITS-1:0] w1_q;
  logic signed [SAMPLE_BITS-1:0] x1_q;
  logic signed [BIAS_BITS-1:0]   b1_q;

  logic                          v2_q, first2_q, last2_q;
  logic [FW-1:0]                 f2_q;
  logic signed [PW-1:0]          prod2_q;
  logic signed [BIAS_BITS-1:0]   b2_q;

  logic signed [ACC_W-1:0]       acc_q, acc_base, acc_sum;
  logic signed [RES_BITS-1:0]    res_val;
  logic                          res_sat;

  logic                          out_valid_q;
  logic [FIDX_BITS-1:0]          out_f_q;
  logic [POS_BITS-1:0]           out_pos_q;
  logic signed [RES_BITS-1:0]    out_val_q;
  logic                          out_sat_q, out_last_q;

  // register clamping
  always_comb begin
    if (taps_i == '0) begin
      k_cfg = TW'(1);
    end else if (int'(taps_i) > MAX_TAPS) begin
      k_cfg = TW'(MAX_TAPS);
    end else begin
      k_cfg = TW'(taps_i);
    end
    if (filters_i == '0) begin
      nf_cfg = FW'(1);
    end else if (int'(filters_i) > MAX_FILTERS) begin
      nf_cfg = FW'(MAX_FILTERS);
    end else begin
      nf_cfg = FW'(filters_i);
    end
  end

  assign adv   = !(v2_q && last2_q && out_valid_q && !out_ready_i);
  assign pop_o = item_valid_i && (state_q == BK_IDLE) && !v1_q && !v2_q;

  assign fill_base = item_ctl_i.seq_start ? '0 : fill_q;
  assign fill_new  = (fill_base == TW'(MAX_TAPS)) ? fill_base : fill_base + 1'b1;
  assign pos_base  = item_ctl_i.seq_start ? '0 : pos_q;
  assign start_run = pop_o && (item_ctl_i.kind == KIND_SAMPLE) && (fill_new >= k_cfg);

  assign last_j = j_q == k_q - 1'b1;
  assign last_c = c_q == CH_LAST;
  assign last_f = f_q == nf_q - 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (start_run) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (adv && last_j && last_c && last_f) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // issue counters
  always_comb begin
    issue = 1'b0;
    f_d   = f_q;
    c_d   = c_q;
    j_d   = j_q;
    case (state_q)
      BK_IDLE: begin
        if (start_run) begin
          f_d = '0;
          c_d = '0;
          j_d = '0;
        end
      end
      BK_RUN: begin
        issue = adv;
        if (adv) begin
          if (last_j) begin
            j_d = '0;
            if (last_c) begin
              c_d = '0;
              f_d = f_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      default: issue = 1'b0;
    endcase
  end

  // circular window: np_q points at the newest sample
  assign np_d     = (np_q == WIN_W'(MAX_TAPS - 1)) ? '0 : np_q + 1'b1;
  assign win_dist = k_q - 1'b1 - j_q;
  assign win_idx  = (TW'(np_q) >= win_dist) ? TW'(np_q) - win_dist
                  : TW'(np_q) + TW'(MAX_TAPS) - win_dist;

  assign rd_addr = AW2'(f_q) * AW2'(CHANNELS * MAX_TAPS) + AW2'(c_q) * AW2'(MAX_TAPS)
                 + AW2'(j_q);
  assign ld_addr = AW2'(item_ctl_i.fsel) * AW2'(CHANNELS * MAX_TAPS)
                 + AW2'(item_ctl_i.csel) * AW2'(MAX_TAPS) + AW2'(item_ctl_i.tsel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      fill_q  <= '0;
      pos_q   <= '0;
      np_q    <= '0;
      f_q     <= '0;
      c_q     <= '0;
      j_q     <= '0;
      k_q     <= TW'(1);
      nf_q    <= FW'(1);
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      f_q     <= f_d;
      c_q     <= c_d;
      j_q     <= j_d;
      if (pop_o && (item_ctl_i.kind == KIND_SAMPLE)) begin
        fill_q <= fill_new;
        np_q   <= np_d;
        if (start_run) begin
          pos_q <= (pos_base == '1) ? pos_base : pos_base + 1'b1;
          k_q   <= k_cfg;
          nf_q  <= nf_cfg;
        end else begin
          pos_q <= pos_base;
        end
      end
      if (adv) begin
        v1_q <= issue;
        v2_q <= v1_q;
      end
    end
  end

  // memories and window
  always_ff @(posedge clk_i) begin
    if (pop_o && (item_ctl_i.kind == KIND_WEIGHT)) begin
      wmem[ld_addr[ADDR_W-1:0]] <= item_data_i[WEIGHT_BITS-1:0];
    end
    if (pop_o && (item_ctl_i.kind == KIND_BIAS)) begin
      bmem[BF_W'(item_ctl_i.fsel)] <= item_data_i[BIAS_BITS-1:0];
    end
    if (issue) begin
      w1_q <= wmem[rd_addr[ADDR_W-1:0]];
      b1_q <= bmem[BF_W'(f_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (item_ctl_i.kind == KIND_SAMPLE)) begin
      win_mem[np_d] <= item_data_i[CHANNELS*SAMPLE_BITS-1:0];
    end
    if (issue) begin
      x1_q <= win_mem[win_idx[WIN_W-1:0]][int'(CH_LAST - c_q) * SAMPLE_BITS +: SAMPLE_BITS];
    end
    if (start_run) begin
      curpos_q <= pos_base;
    end
  end

  // datapath pipeline
  always_ff @(posedge clk_i) begin
    if (issue) begin
      first1_q <= (c_q == '0) && (j_q == '0);
      last1_q  <= last_c && last_j;
      f1_q     <= f_q;
    end
    if (adv) begin
      prod2_q  <= PW'(x1_q) * PW'(w1_q);
      b2_q     <= b1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      f2_q     <= f1_q;
      if (v2_q) begin
        acc_q <= acc_sum;
      end
    end
  end

  assign acc_base = first2_q ? ACC_W'(b2_q) : acc_q;
  assign acc_sum  = acc_base + ACC_W'(prod2_q);

  always_comb begin
    res_sat = 1'b1;
    if (acc_sum > SAT_HI) begin
      res_val = 32'sh7fffffff;
    end else if (acc_sum < SAT_LO) begin
      res_val = 32'sh80000000;
    end else begin
      res_val = acc_sum[RES_BITS-1:0];
      res_sat = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && v2_q && last2_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q && last2_q) begin
      out_f_q    <= FIDX_BITS'(f2_q);
      out_pos_q  <= curpos_q;
      out_val_q  <= res_val;
      out_sat_q  <= res_sat;
      out_last_q <= f2_q == nf_q - 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filter_index_o = out_f_q;
  assign out_position_o = out_pos_q;
  assign conv_value_o   = out_val_q;
  assign saturated_o    = out_sat_q;
  assign last_of_run_o  = out_last_q;

endmodule

/* src/conv1d_four_channel_filter_bank.sv */
// ----------------------------------------------------------------------------
// conv1d_four_channel_filter_bank
// Streaming 1-D valid convolution over four-channel samples, filter bank.
// ----------------------------------------------------------------------------
// channel   signals                          direction
// in        in_valid_i / in_ready_o          load or sample transaction in
// out       out_valid_o / out_ready_i        one filter result out
// cfg       cfg_valid_i / cfg_ready_o        register write, index and data
//
// A load is executed in the back end while it is idle. A sample that completes a
// window runs one multiply-accumulate per filter, channel and tap, one per cycle
// while the result is not stalled, against the single-port weight memory.
// Reset clears control state only; weights and biases must be loaded first.
// A stalled result holds the MAC pipeline; the two-entry queue keeps
// accepting transactions meanwhile until it is full.
// ----------------------------------------------------------------------------
module conv1d_four_channel_filter_bank import c1d_pkg::*; #(
  parameter int MAX_TAPS    = 16,
  parameter int MAX_FILTERS = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [3:0]                    filter_sel_i,
  input  logic [1:0]                    channel_sel_i,
  input  logic [3:0]                    tap_sel_i,
  input  logic signed [WEIGHT_BITS-1:0] weight_value_i,
  input  logic signed [BIAS_BITS-1:0]   bias_value_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_a_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_c_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_g_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_t_i,
  input  logic                          seq_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [FIDX_BITS-1:0]          filter_index_o,
  output logic [POS_BITS-1:0]           out_position_o,
  output logic signed [RES_BITS-1:0]    conv_value_o,
  output logic                          saturated_o,
  output logic                          last_of_run_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CFG_BITS-1:0]           cfg_data_i
);

  localparam int DATA_RAW = CHANNELS * SAMPLE_BITS;
  localparam int DATA_W   = (DATA_RAW > BIAS_BITS) ? DATA_RAW : BIAS_BITS;
  localparam int ITEM_W   = CTL_W + DATA_W;

  logic [CFG_BITS-1:0] taps_q, filters_q;
  logic                push, full, q_valid, pop;
  item_ctl_t           f_ctl, b_ctl;
  logic [DATA_W-1:0]   f_data, b_data;
  logic [ITEM_W-1:0]   q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q    <= CFG_BITS'(16);
      filters_q <= CFG_BITS'(16);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TAPS:    taps_q    <= cfg_data_i;
        CFG_FILTERS: filters_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  c1d_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS),
    .MAX_FILTERS (MAX_FILTERS),
    .DATA_W      (DATA_W)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .filter_sel_i   (filter_sel_i),
    .channel_sel_i  (channel_sel_i),
    .tap_sel_i      (tap_sel_i),
    .weight_value_i (weight_value_i),
    .bias_value_i   (bias_value_i),
    .sample_a_i     (sample_a_i),
    .sample_c_i     (sample_c_i),
    .sample_g_i     (sample_g_i),
    .sample_t_i     (sample_t_i),
    .seq_start_i    (seq_start_i),
    .full_i         (full),
    .push_o         (push),
    .ctl_o          (f_ctl),
    .data_o         (f_data)
  );

  c1d_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_ctl, f_data}),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_out)
  );

  assign b_ctl  = q_out[ITEM_W-1 -: CTL_W];
  assign b_data = q_out[DATA_W-1:0];

  c1d_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS),
    .MAX_FILTERS (MAX_FILTERS),
    .DATA_W      (DATA_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .taps_i         (taps_q),
    .filters_i      (filters_q),
    .item_valid_i   (q_valid),
    .item_ctl_i     (b_ctl),
    .item_data_i    (b_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .filter_index_o (filter_index_o),
    .out_position_o (out_position_o),
    .conv_value_o   (conv_value_o),
    .saturated_o    (saturated_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

/* src/c1d_checker.sv */
// ----------------------------------------------------------------------------
// c1d_checker
// Port-level checks of the convolution filter bank, bound to the top level.
// ----------------------------------------------------------------------------
module c1d_checker import c1d_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [RES_BITS-1:0] conv_value_o,
  input logic                       saturated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(conv_value_o))
    else $error("result dropped or changed while stalled");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      conv_value_o == 32'sh7fffffff || conv_value_o == 32'sh80000000)
    else $error("saturated result not at a range limit");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind conv1d_four_channel_filter_bank c1d_checker u_c1d_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .conv_value_o (conv_value_o),
  .saturated_o  (saturated_o)
);

/* tb/tb_conv1d_four_channel_filter_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv1d_four_channel_filter_bank
// Self-checking testbench: loads the biases and the weights that the tested
// shapes use, then runs directed and random sample streams across several
// kernel and filter settings while both handshakes stall at random. Every
// filter result is compared with a cycle-free model of the convolution.
// ----------------------------------------------------------------------------
module tb_conv1d_four_channel_filter_bank;
  import c1d_pkg::*;

  localparam int NTAPS     = 16;
  localparam int NFILT     = 16;
  localparam int WD_LIMIT  = 20000;
  localparam int SETTLE    = 60;

  typedef struct {
    kind_e              kind;
    logic [3:0]         fsel;
    logic [1:0]         csel;
    logic [3:0]         tsel;
    logic signed [15:0] wval;
    logic signed [31:0] bval;
    logic signed [15:0] smp [CHANNELS];
    logic               seq;
  } conv_item_t;

  typedef struct {
    logic [3:0]         fidx;
    logic [15:0]        pos;
    logic signed [31:0] val;
    logic               sat;
    logic               last;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind = '0;
  logic [3:0]         filter_sel = '0;
  logic [1:0]         channel_sel = '0;
  logic [3:0]         tap_sel = '0;
  logic signed [15:0] weight_value = '0;
  logic signed [31:0] bias_value = '0;
  logic signed [15:0] sample_a = '0, sample_c = '0, sample_g = '0, sample_t = '0;
  logic               seq_start = 1'b0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic [3:0]         filter_index_o;
  logic [15:0]        out_position_o;
  logic signed [31:0] conv_value_o;
  logic               saturated_o;
  logic               last_of_run_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index = '0;
  logic [4:0]         cfg_data = '0;

  conv1d_four_channel_filter_bank u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind),
    .filter_sel_i   (filter_sel),
    .channel_sel_i  (channel_sel),
    .tap_sel_i      (tap_sel),
    .weight_value_i (weight_value),
    .bias_value_i   (bias_value),
    .sample_a_i     (sample_a),
    .sample_c_i     (sample_c),
    .sample_g_i     (sample_g),
    .sample_t_i     (sample_t),
    .seq_start_i    (seq_start),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .filter_index_o (filter_index_o),
    .out_position_o (out_position_o),
    .conv_value_o   (conv_value_o),
    .saturated_o    (saturated_o),
    .last_of_run_o  (last_of_run_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state
  logic signed [15:0] m_weight [NFILT][CHANNELS][NTAPS];
  logic signed [31:0] m_bias [NFILT];
  logic signed [15:0] m_window [CHANNELS][NTAPS];
  int unsigned        m_fill = 0;
  int unsigned        m_pos = 0;
  logic [4:0]         m_taps = 5'd16;
  logic [4:0]         m_filters = 5'd16;

  conv_result_t expected_q [$];
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  int  hold_left = 0;
  int  n_mismatch = 0;
  int  idle_cycles = 0;

  function automatic int unsigned clamp16(logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  task automatic predict_conv(input conv_item_t it);
    int unsigned k, nf;
    longint acc;
    conv_result_t r;
    case (it.kind)
      KIND_WEIGHT: m_weight[it.fsel][it.csel][it.tsel] = it.wval;
      KIND_BIAS:   m_bias[it.fsel] = it.bval;
      KIND_SAMPLE: begin
        if (it.seq) begin
          m_fill = 0;
          m_pos = 0;
        end
        for (int c = 0; c < CHANNELS; c++) begin
          for (int j = NTAPS - 1; j > 0; j--) m_window[c][j] = m_window[c][j-1];
          m_window[c][0] = it.smp[c];
        end
        if (m_fill < NTAPS) m_fill++;
        k = clamp16(m_taps);
        nf = clamp16(m_filters);
        if (m_fill >= k) begin
          for (int f = 0; f < nf; f++) begin
            acc = longint'(m_bias[f]);
            for (int c = 0; c < CHANNELS; c++)
              for (int j = 0; j < k; j++)
                acc += longint'(m_window[c][k-1-j]) * longint'(m_weight[f][c][j]);
            r.sat = 1'b0;
            if (acc > 64'sd2147483647) begin
              acc = 64'sd2147483647;
              r.sat = 1'b1;
            end else if (acc < -64'sd2147483648) begin
              acc = -64'sd2147483648;
              r.sat = 1'b1;
            end
            r.fidx = f[3:0];
            r.pos = m_pos[15:0];
            r.val = acc[31:0];
            r.last = (f + 1 == nf);
            expected_q.push_back(r);
          end
          if (m_pos < 65535) m_pos++;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input conv_item_t it);
    int gap;
    gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    kind         <= it.kind;
    filter_sel   <= it.fsel;
    channel_sel  <= it.csel;
    tap_sel      <= it.tsel;
    weight_value <= it.wval;
    bias_value   <= it.bval;
    sample_a     <= it.smp[0];
    sample_c     <= it.smp[1];
    sample_g     <= it.smp[2];
    sample_t     <= it.smp[3];
    seq_start    <= it.seq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_conv(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [4:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_TAPS) m_taps = val;
    else m_filters = val;
  endtask

  task automatic set_shape(input logic [4:0] taps, input logic [4:0] filters);
    write_reg(CFG_TAPS, taps);
    write_reg(CFG_FILTERS, filters);
  endtask

  function automatic logic signed [15:0] rand_sample();
    if ($urandom_range(1)) return 16'($urandom);
    return $signed(16'($urandom_range(8191))) - 16'sd4096;
  endfunction

  function automatic conv_item_t make_sample(input logic seq);
    conv_item_t it;
    it.kind = KIND_SAMPLE;
    it.fsel = 4'($urandom);
    it.csel = 2'($urandom);
    it.tsel = 4'($urandom);
    it.wval = 16'($urandom);
    it.bval = $urandom;
    for (int c = 0; c < CHANNELS; c++) it.smp[c] = rand_sample();
    it.seq = seq;
    return it;
  endfunction

  function automatic conv_item_t make_random();
    conv_item_t it;
    int pick;
    it = make_sample($urandom_range(99) < 8);
    pick = $urandom_range(99);
    if (pick < 10) it.kind = KIND_WEIGHT;
    else if (pick < 15) it.kind = KIND_BIAS;
    else if (pick < 19) it.kind = KIND_NONE;
    if ($urandom_range(1)) it.wval = $signed(16'($urandom_range(2047))) - 16'sd1024;
    return it;
  endfunction

  // all biases; taps 0..1 of every filter, taps 2..3 of filters 0..4,
  // every tap of filter 0
  task automatic test_load_bank();
    conv_item_t it;
    for (int f = 0; f < NFILT; f++) begin
      it = make_sample(1'b0);
      it.kind = KIND_BIAS;
      it.fsel = 4'(f);
      it.bval = (f == 0) ? 32'sh7fffffff : (f == 1) ? 32'sh80000000 : $urandom;
      send_item(it);
      for (int c = 0; c < CHANNELS; c++)
        for (int t = 0; t < NTAPS; t++) begin
          if (t < 2 || (f < 5 && t < 4) || f == 0) begin
            it.kind = KIND_WEIGHT;
            it.csel = 2'(c);
            it.tsel = 4'(t);
            it.wval = (f == 2) ? 16'sh7fff : (f == 3) ? 16'sh8000 :
                      $signed(16'($urandom_range(4095))) - 16'sd2048;
            if (f > 8) it.wval = 16'($urandom);
            send_item(it);
          end
        end
    end
  endtask

  task automatic test_directed();
    conv_item_t it;
    set_shape(5'd1, 5'd1);
    it = make_sample(1'b1);
    it.smp = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    send_item(it);
    it = make_sample(1'b0);
    it.smp = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_item(it);
    it.smp = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
    send_item(it);
    it.kind = KIND_NONE;
    send_item(it);
    // clamped register values
    set_shape(5'd0, 5'd31);
    send_item(make_sample(1'b1));
    send_item(make_sample(1'b0));
    set_shape(5'd31, 5'd1);
    for (int i = 0; i < 17; i++) send_item(make_sample(i == 0));
    // shorter kernel mid-sequence, then longer than the fill
    set_shape(5'd3, 5'd3);
    send_item(make_sample(1'b0));
    set_shape(5'd6, 5'd1);
    for (int i = 0; i < 7; i++) send_item(make_sample(i == 0));
    it = make_sample(1'b0);
    it.kind = KIND_BIAS;
    it.fsel = 4'd0;
    it.bval = 32'sh00000000;
    send_item(it);
    send_item(make_sample(1'b0));
  endtask

  task automatic test_random_phase(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 15 == 0) set_shape(5'($urandom_range(1, 4)), 5'($urandom_range(1, 5)));
      send_item(make_random());
    end
  endtask

  task automatic test_all_filters();
    set_shape(5'd2, 5'd16);
    for (int i = 0; i < 19; i++) send_item(make_sample(i == 0));
  endtask

  task automatic test_backpressure();
    set_shape(5'd2, 5'd3);
    hold_left = 3000;
    for (int i = 0; i < 30; i++) send_item(make_sample(i == 0));
    drain_results();
  endtask

  // result checker and ready generator
  always @(posedge clk_i) begin
    conv_result_t e;
    if (out_valid_o && out_ready) begin
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result transaction: filter %0d pos %0d value %0d",
                   filter_index_o, out_position_o, conv_value_o);
      end else begin
        e = expected_q.pop_front();
        if (filter_index_o !== e.fidx || out_position_o !== e.pos ||
            conv_value_o !== e.val || saturated_o !== e.sat ||
            last_of_run_o !== e.last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result mismatch: exp f%0d p%0d v%0d s%0b l%0b got f%0d p%0d v%0d s%0b l%0b",
                     e.fidx, e.pos, e.val, e.sat, e.last, filter_index_o,
                     out_position_o, conv_value_o, saturated_o, last_of_run_o);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("conv1d_four_channel_filter_bank: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    snd_idle_pct = 16;
    rcv_idle_pct = 78;
    test_load_bank();
    test_directed();
    test_random_phase(45);
    test_backpressure();
    snd_idle_pct = 78;
    rcv_idle_pct = 16;
    test_random_phase(45);
    test_all_filters();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_phase(45);
    drain_results();
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("conv1d_four_channel_filter_bank: match");
    end else begin
      $display("conv1d_four_channel_filter_bank: mismatch");
    end
    $finish;
  end

endmodule
